### rtl/assert_macros.svh
// Assertion macros used by the top level of the IR pulse command decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on the rising clock edge, ignored while reset is active.
`define IPCD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check a property on the rising clock edge, also during reset.
`define IPCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IPCD_ASSERT(lbl, clk, rstn, prop, msg)
`define IPCD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/ipcd_pkg.sv
// Types, constants and the remote code table of the IR pulse command decoder.
package ipcd_pkg;

  localparam int unsigned TIMER_W   = 16;
  localparam int unsigned CMD_W     = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned HOLD_W    = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH         = 3'd4;

  localparam logic [CFG_W-1:0] HEADER_THRESHOLD_RST = 16'd8000;
  localparam logic [CFG_W-1:0] ZERO_LOW_RST         = 16'd800;
  localparam logic [CFG_W-1:0] ZERO_HIGH_RST        = 16'd1120;
  localparam logic [CFG_W-1:0] ONE_LOW_RST          = 16'd2230;
  localparam logic [CFG_W-1:0] ONE_HIGH_RST         = 16'd5870;

  typedef enum logic [1:0] {
    CLASS_HEADER = 2'd0,
    CLASS_ZERO   = 2'd1,
    CLASS_ONE    = 2'd2,
    CLASS_IGNORE = 2'd3
  } pulse_class_e;

  // Remote codes
  localparam logic [CMD_W-1:0] CODE_LED0  = 16'hD827;
  localparam logic [CMD_W-1:0] CODE_RIGHT = 16'hA05F;
  localparam logic [CMD_W-1:0] CODE_LEFT  = 16'h00FF;
  localparam logic [CMD_W-1:0] CODE_LED3  = 16'hF807;
  localparam logic [CMD_W-1:0] CODE_FWD   = 16'h807F;
  localparam logic [CMD_W-1:0] CODE_SLOW  = 16'h10EF;
  localparam logic [CMD_W-1:0] CODE_LED6  = 16'h7887;
  localparam logic [CMD_W-1:0] CODE_ALL   = 16'h58A7;
  localparam logic [CMD_W-1:0] CODE_FULL  = 16'h20DF;

  localparam logic [HOLD_W-1:0] DUTY_HIGH = 8'd242;
  localparam logic [HOLD_W-1:0] DUTY_MID  = 8'd150;
  localparam logic [HOLD_W-1:0] DUTY_LOW  = 8'd120;
  localparam logic [HOLD_W-1:0] DUTY_MAX  = 8'd255;

  typedef struct packed {
    logic              hit;
    logic              motors;
    logic [HOLD_W-1:0] led;
    logic [HOLD_W-1:0] right;
    logic [HOLD_W-1:0] left;
  } code_hit_t;

  function automatic code_hit_t ipcd_lookup(input logic [CMD_W-1:0] cmd);
    code_hit_t r;
    r = '0;
    case (cmd)
      CODE_LED0: begin
        r.hit = 1'b1; r.led = 8'h01;
      end
      CODE_RIGHT: begin
        r.hit = 1'b1; r.led = 8'h02; r.motors = 1'b1;
        r.right = DUTY_MID; r.left = DUTY_HIGH;
      end
      CODE_LEFT: begin
        r.hit = 1'b1; r.led = 8'h04; r.motors = 1'b1;
        r.right = DUTY_HIGH; r.left = DUTY_MID;
      end
      CODE_LED3: begin
        r.hit = 1'b1; r.led = 8'h08;
      end
      CODE_FWD: begin
        r.hit = 1'b1; r.led = 8'h10; r.motors = 1'b1;
        r.right = DUTY_HIGH; r.left = DUTY_HIGH;
      end
      CODE_SLOW: begin
        r.hit = 1'b1; r.led = 8'h20; r.motors = 1'b1;
        r.right = DUTY_LOW; r.left = DUTY_LOW;
      end
      CODE_LED6: begin
        r.hit = 1'b1; r.led = 8'h40;
      end
      CODE_ALL: begin
        r.hit = 1'b1; r.led = 8'hFF;
      end
      CODE_FULL: begin
        r.hit = 1'b1; r.led = 8'h80; r.motors = 1'b1;
        r.right = DUTY_MAX; r.left = DUTY_MAX;
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

endpackage

### rtl/ipcd_if.sv
// Valid/ready channel interfaces of the IR pulse command decoder.
interface ipcd_edge_if import ipcd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TIMER_W-1:0] edge_time;

  modport source (output valid, output edge_time, input ready);
  modport sink (input valid, input edge_time, output ready);
endinterface

interface ipcd_result_if import ipcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        pulse_class;
  logic [CMD_W-1:0]  command_word;
  logic [HOLD_W-1:0] led_pattern;
  logic [HOLD_W-1:0] right_duty;
  logic [HOLD_W-1:0] left_duty;

  modport source (output valid, output pulse_class, output command_word,
                  output led_pattern, output right_duty, output left_duty,
                  input ready);
  modport sink (input valid, input pulse_class, input command_word,
                input led_pattern, input right_duty, input left_duty,
                output ready);
endinterface

interface ipcd_cfg_if import ipcd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/ir_pulse_command_decoder.sv
// Top level of the IR pulse command decoder: edge interval classifier and code matcher.
//
// Channels: edge_i carries the timer stamp of one receiver edge; result_o
// carries the interval class, the command shift register after that edge,
// the held LED pattern and the two held motor duties. cfg_i writes the
// five timing registers (header threshold, zero window, one window) by
// index; it is always ready and a write to an unused index does nothing.
//
// An accepted item is held in the input register; the interval, the
// classification, the shift and the code lookup then run combinationally
// into the result register, which shows the result. One item is taken
// every cycle while the result register is free or its result is taken;
// the subtract, compares and table lookup lie between the two registers.
//
// Reset clears the previous stamp, the command register and the held
// LED and duty values, and loads the timing registers with their defaults.
// When the receiver stalls, the result register holds its item and the
// input register takes one more; after that edge_i.ready drops until the
// result is taken.
module ir_pulse_command_decoder import ipcd_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  ipcd_cfg_if.sink          cfg_i,
  ipcd_edge_if.sink         edge_i,
  ipcd_result_if.source     result_o
);

`include "assert_macros.svh"

  // Timing registers
  logic [CFG_W-1:0] hdr_thr_q, zero_lo_q, zero_hi_q, one_lo_q, one_hi_q;

  // Input stage
  logic               s1_valid_q;
  logic [TIMER_W-1:0] s1_time_q;

  // Decoder state
  logic [TIMER_W-1:0] last_time_q;
  logic [CMD_W-1:0]   cmd_q, cmd_d;
  logic [HOLD_W-1:0]  led_q, led_d;
  logic [HOLD_W-1:0]  right_q, right_d;
  logic [HOLD_W-1:0]  left_q, left_d;

  // Result stage
  logic              out_valid_q;
  pulse_class_e      out_class_q, cls_d;
  logic [CMD_W-1:0]  out_cmd_q;
  logic [HOLD_W-1:0] out_led_q, out_right_q, out_left_q;

  logic               advance;
  logic               edge_acc;
  logic [TIMER_W-1:0] interval;
  code_hit_t          hit;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_thr_q <= HEADER_THRESHOLD_RST;
      zero_lo_q <= ZERO_LOW_RST;
      zero_hi_q <= ZERO_HIGH_RST;
      one_lo_q  <= ONE_LOW_RST;
      one_hi_q  <= ONE_HIGH_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_HEADER_THRESHOLD: hdr_thr_q <= cfg_i.data;
        CFG_ZERO_LOW:         zero_lo_q <= cfg_i.data;
        CFG_ZERO_HIGH:        zero_hi_q <= cfg_i.data;
        CFG_ONE_LOW:          one_lo_q  <= cfg_i.data;
        CFG_ONE_HIGH:         one_hi_q  <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  // Process the held item when the result register is free or being emptied
  assign advance      = s1_valid_q && (!out_valid_q || result_o.ready);
  assign edge_i.ready = !s1_valid_q || advance;
  assign edge_acc     = edge_i.valid && edge_i.ready;

  assign interval = s1_time_q - last_time_q;

  always_comb begin
    cmd_d = cmd_q;
    cls_d = CLASS_IGNORE;
    if (interval > hdr_thr_q) begin
      cmd_d = '0;
      cls_d = CLASS_HEADER;
    end else if (interval > zero_lo_q && interval < zero_hi_q) begin
      cmd_d = {cmd_q[CMD_W-2:0], 1'b0};
      cls_d = CLASS_ZERO;
    end else if (interval > one_lo_q && interval < one_hi_q) begin
      cmd_d = {cmd_q[CMD_W-2:0], 1'b1};
      cls_d = CLASS_ONE;
    end
  end

  assign hit = ipcd_lookup(cmd_d);

  always_comb begin
    led_d   = led_q;
    right_d = right_q;
    left_d  = left_q;
    if (hit.hit) begin
      led_d = hit.led;
      if (hit.motors) begin
        right_d = hit.right;
        left_d  = hit.left;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_time_q <= '0;
      cmd_q       <= '0;
      led_q       <= '0;
      right_q     <= '0;
      left_q      <= '0;
    end else begin
      if (edge_i.ready) begin
        s1_valid_q <= edge_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        last_time_q <= s1_time_q;
        cmd_q       <= cmd_d;
        led_q       <= led_d;
        right_q     <= right_d;
        left_q      <= left_d;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (edge_acc) begin
      s1_time_q <= edge_i.edge_time;
    end
    if (advance) begin
      out_class_q <= cls_d;
      out_cmd_q   <= cmd_d;
      out_led_q   <= led_d;
      out_right_q <= right_d;
      out_left_q  <= left_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.pulse_class  = out_class_q;
  assign result_o.command_word = out_cmd_q;
  assign result_o.led_pattern  = out_led_q;
  assign result_o.right_duty   = out_right_q;
  assign result_o.left_duty    = out_left_q;

  `IPCD_ASSERT(a_hold_stalled_item, clk_i, rst_ni, s1_valid_q && !advance |=> s1_valid_q, "held item lost while stalled")
  `IPCD_ASSERT(a_advance_fills_out, clk_i, rst_ni, advance |=> out_valid_q && out_cmd_q == cmd_q, "result register out of step with command state")
  `IPCD_ASSERT(a_header_clears_cmd, clk_i, rst_ni, out_valid_q && out_class_q == CLASS_HEADER |-> out_cmd_q == '0, "header result with nonzero command word")
  `IPCD_ASSERT(a_zero_shifts_zero, clk_i, rst_ni, advance && cls_d == CLASS_ZERO |=> !cmd_q[0] && cmd_q[CMD_W-1:1] == $past(cmd_q[CMD_W-2:0]), "zero bit not shifted in")

endmodule
